// File: hdl/ebe_pkg.sv
package ebe_pkg;

    localparam logic [1:0] REG_CODE_FORMAT  = 2'd0;
    localparam logic [1:0] REG_MODULE_WIDTH = 2'd1;
    localparam logic [1:0] REG_START_OFFSET = 2'd2;

    // Guard patterns, left aligned in a 7-bit field.
    localparam logic [6:0] GUARD_SIDE   = 7'b1010000;
    localparam logic [6:0] GUARD_CENTER = 7'b0101000;
    localparam logic [2:0] GUARD_SIDE_BITS   = 3'd3;
    localparam logic [2:0] GUARD_CENTER_BITS = 3'd5;
    localparam logic [2:0] SYMBOL_BITS       = 3'd7;

    // One run of module bits handed to the serializer.
    typedef struct packed {
        logic [6:0] pattern;
        logic [2:0] nbits;
        logic       is_init;
        logic       is_final;
        logic [3:0] chk;
    } seg_t;

    // One output bit handed to the byte packer.
    typedef struct packed {
        logic       value;
        logic       first;
        logic       is_final;
        logic [3:0] chk;
    } mbit_t;

    function automatic logic [6:0] set_a(input logic [3:0] d);
        logic [6:0] r;
        case (d)
            4'd0:    r = 7'h0D;
            4'd1:    r = 7'h19;
            4'd2:    r = 7'h13;
            4'd3:    r = 7'h3D;
            4'd4:    r = 7'h23;
            4'd5:    r = 7'h31;
            4'd6:    r = 7'h2F;
            4'd7:    r = 7'h3B;
            4'd8:    r = 7'h37;
            default: r = 7'h0B;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] set_b(input logic [3:0] d);
        logic [6:0] r;
        case (d)
            4'd0:    r = 7'h27;
            4'd1:    r = 7'h33;
            4'd2:    r = 7'h1B;
            4'd3:    r = 7'h21;
            4'd4:    r = 7'h1D;
            4'd5:    r = 7'h39;
            4'd6:    r = 7'h05;
            4'd7:    r = 7'h11;
            4'd8:    r = 7'h09;
            default: r = 7'h17;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] set_c(input logic [3:0] d);
        logic [6:0] r;
        case (d)
            4'd0:    r = 7'h72;
            4'd1:    r = 7'h66;
            4'd2:    r = 7'h6C;
            4'd3:    r = 7'h42;
            4'd4:    r = 7'h5C;
            4'd5:    r = 7'h4E;
            4'd6:    r = 7'h50;
            4'd7:    r = 7'h44;
            4'd8:    r = 7'h48;
            default: r = 7'h74;
        endcase
        return r;
    endfunction

    // Bit (5 - i) set: left-half position i uses set B.
    function automatic logic [5:0] parity_mask(input logic [3:0] d);
        logic [5:0] r;
        case (d)
            4'd0:    r = 6'h00;
            4'd1:    r = 6'h0B;
            4'd2:    r = 6'h0D;
            4'd3:    r = 6'h0E;
            4'd4:    r = 6'h13;
            4'd5:    r = 6'h19;
            4'd6:    r = 6'h1C;
            4'd7:    r = 6'h15;
            4'd8:    r = 6'h16;
            default: r = 6'h1A;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/ean_barcode_bit_encoder_top.sv
// EAN-13 / EAN-8 barcode encoder. Digits enter one transaction at a time,
// most significant first (twelve for EAN-13, seven for EAN-8); the block
// emits the barcode as bytes of module bits, first module in bit 7 minus the
// start offset, with guards, the check digit after the last digit, and
// last_byte with check_digit on the final byte. A digit takes its segments
// (start guard, symbol, center guard, check symbol, end guard) through a bit
// serializer that sends one output bit per cycle within a segment unless the
// byte output stalls. Register writes take effect at once and restart the
// code.
module ean_barcode_bit_encoder_top #(
    parameter int MAX_MODULE_WIDTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data,
    input  logic       digit_valid,
    output logic       digit_ready,
    input  logic [3:0] digit,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       last_byte,
    output logic [3:0] check_digit
);

    localparam logic [3:0] MAXW = 4'(MAX_MODULE_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DATA,
        S_CENTER,
        S_CHECK,
        S_END
    } state_t;

    state_t     state_reg;
    logic       fmt_reg;
    logic [2:0] mw_reg;
    logic [2:0] offset_reg;
    logic [3:0] pos_reg;
    logic [3:0] psel_reg;
    logic [3:0] sum_reg;
    logic [6:0] data_pat_reg;
    logic       do_data_reg;
    logic       do_center_reg;
    logic       last_reg;
    logic [3:0] chk_reg;

    logic       cfg_hit;
    logic       accept;
    logic [3:0] d;
    logic       weight3;
    logic [4:0] prod;
    logic [5:0] total;
    logic [3:0] sum_next;
    logic [3:0] chk_next;
    logic       last_next;
    logic [5:0] pmask;
    logic [2:0] pidx;
    logic [6:0] data_pat_next;
    logic [2:0] width_m1;

    logic            seg_valid;
    logic            seg_ready;
    ebe_pkg::seg_t   seg;
    logic            bit_valid;
    logic            bit_ready;
    ebe_pkg::mbit_t  mbit;

    assign cfg_hit     = cfg_we && (cfg_index == ebe_pkg::REG_CODE_FORMAT
                                 || cfg_index == ebe_pkg::REG_MODULE_WIDTH
                                 || cfg_index == ebe_pkg::REG_START_OFFSET);
    // A register write wins over a digit offered in the same cycle.
    assign digit_ready = (state_reg == S_IDLE) && !cfg_hit;
    assign accept      = digit_valid && digit_ready;

    always_comb
    begin
        if (mw_reg == 3'd0)
        begin
            width_m1 = 3'd0;
        end
        else if ({1'b0, mw_reg} > MAXW)
        begin
            width_m1 = 3'(MAXW - 4'd1);
        end
        else
        begin
            width_m1 = mw_reg - 3'd1;
        end
    end

    // Check sum is kept modulo ten; each step adds at most 27.
    always_comb
    begin
        d        = (digit > 4'd9) ? 4'd9 : digit;
        weight3  = fmt_reg ? !pos_reg[0] : pos_reg[0];
        prod     = weight3 ? ({1'b0, d} + {d, 1'b0}) : {1'b0, d};
        total    = {2'b00, sum_reg} + {1'b0, prod};
        if (total >= 6'd30)
        begin
            sum_next = 4'(total - 6'd30);
        end
        else if (total >= 6'd20)
        begin
            sum_next = 4'(total - 6'd20);
        end
        else if (total >= 6'd10)
        begin
            sum_next = 4'(total - 6'd10);
        end
        else
        begin
            sum_next = total[3:0];
        end
        chk_next  = (sum_next == 4'd0) ? 4'd0 : 4'd10 - sum_next;
        last_next = fmt_reg ? (pos_reg >= 4'd6) : (pos_reg >= 4'd11);

        pmask = ebe_pkg::parity_mask(psel_reg);
        pidx  = 3'(4'd6 - pos_reg);
        if (fmt_reg)
        begin
            data_pat_next = (pos_reg < 4'd4) ? ebe_pkg::set_a(d) : ebe_pkg::set_c(d);
        end
        else if (pos_reg <= 4'd6)
        begin
            data_pat_next = pmask[pidx] ? ebe_pkg::set_b(d) : ebe_pkg::set_a(d);
        end
        else
        begin
            data_pat_next = ebe_pkg::set_c(d);
        end
    end

    always_comb
    begin
        seg.pattern  = ebe_pkg::GUARD_SIDE;
        seg.nbits    = ebe_pkg::GUARD_SIDE_BITS;
        seg.is_init  = 1'b0;
        seg.is_final = 1'b0;
        seg.chk      = chk_reg;
        seg_valid    = 1'b1;
        case (state_reg)
            S_START:
            begin
                seg.is_init = 1'b1;
            end
            S_DATA:
            begin
                seg.pattern = data_pat_reg;
                seg.nbits   = ebe_pkg::SYMBOL_BITS;
            end
            S_CENTER:
            begin
                seg.pattern = ebe_pkg::GUARD_CENTER;
                seg.nbits   = ebe_pkg::GUARD_CENTER_BITS;
            end
            S_CHECK:
            begin
                seg.pattern = ebe_pkg::set_c(chk_reg);
                seg.nbits   = ebe_pkg::SYMBOL_BITS;
            end
            S_END:
            begin
                seg.is_final = 1'b1;
            end
            default:
            begin
                seg_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fmt_reg       <= 1'b0;
            mw_reg        <= 3'd1;
            offset_reg    <= 3'd0;
            pos_reg       <= '0;
            psel_reg      <= '0;
            sum_reg       <= '0;
            data_pat_reg  <= '0;
            do_data_reg   <= 1'b0;
            do_center_reg <= 1'b0;
            last_reg      <= 1'b0;
            chk_reg       <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                ebe_pkg::REG_CODE_FORMAT:  fmt_reg    <= cfg_data[0];
                ebe_pkg::REG_MODULE_WIDTH: mw_reg     <= cfg_data;
                default:                   offset_reg <= cfg_data;
            endcase
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            psel_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        data_pat_reg  <= data_pat_next;
                        do_data_reg   <= fmt_reg || (pos_reg != 4'd0);
                        do_center_reg <= fmt_reg ? (pos_reg == 4'd3) : (pos_reg == 4'd6);
                        last_reg      <= last_next;
                        chk_reg       <= chk_next;
                        if (!fmt_reg && pos_reg == 4'd0)
                        begin
                            psel_reg <= d;
                        end
                        if (last_next)
                        begin
                            pos_reg  <= '0;
                            sum_reg  <= '0;
                            psel_reg <= '0;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 4'd1;
                            sum_reg <= sum_next;
                        end
                        state_reg <= (pos_reg == 4'd0) ? S_START : S_DATA;
                    end
                end
                S_START:
                begin
                    if (seg_ready)
                    begin
                        state_reg <= do_data_reg ? S_DATA : S_IDLE;
                    end
                end
                S_DATA:
                begin
                    if (seg_ready)
                    begin
                        if (do_center_reg)
                        begin
                            state_reg <= S_CENTER;
                        end
                        else
                        begin
                            state_reg <= last_reg ? S_CHECK : S_IDLE;
                        end
                    end
                end
                S_CENTER:
                begin
                    if (seg_ready)
                    begin
                        state_reg <= last_reg ? S_CHECK : S_IDLE;
                    end
                end
                S_CHECK:
                begin
                    if (seg_ready)
                    begin
                        state_reg <= S_END;
                    end
                end
                S_END:
                begin
                    if (seg_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ebe_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .width_m1  (width_m1),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .bit_valid (bit_valid),
        .bit_ready (bit_ready),
        .mbit      (mbit)
    );

    ebe_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_hit),
        .start_offset (offset_reg),
        .bit_valid    (bit_valid),
        .bit_ready    (bit_ready),
        .mbit         (mbit),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .check_digit  (check_digit)
    );

endmodule

// File: hdl/ebe_serializer.sv
module ebe_serializer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          width_m1,
    input  logic                seg_valid,
    output logic                seg_ready,
    input  ebe_pkg::seg_t       seg,
    output logic                bit_valid,
    input  logic                bit_ready,
    output ebe_pkg::mbit_t      mbit
);

    logic       busy_reg;
    logic [6:0] pat_reg;
    logic [2:0] left_reg;
    logic [2:0] rep_reg;
    logic       first_reg;
    logic       final_reg;
    logic [3:0] chk_reg;

    assign seg_ready = !busy_reg;
    assign bit_valid = busy_reg;

    always_comb
    begin
        mbit.value    = pat_reg[6];
        mbit.first    = first_reg;
        mbit.is_final = final_reg && (left_reg == 3'd1) && (rep_reg == width_m1);
        mbit.chk      = chk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
            final_reg <= 1'b0;
            pat_reg   <= '0;
            left_reg  <= '0;
            rep_reg   <= '0;
            chk_reg   <= '0;
        end
        else if (!busy_reg)
        begin
            if (seg_valid)
            begin
                busy_reg  <= 1'b1;
                pat_reg   <= seg.pattern;
                left_reg  <= seg.nbits;
                rep_reg   <= '0;
                first_reg <= seg.is_init;
                final_reg <= seg.is_final;
                chk_reg   <= seg.chk;
            end
        end
        else if (bit_ready)
        begin
            first_reg <= 1'b0;
            // Each module bit is repeated until the width counter wraps.
            if (rep_reg == width_m1)
            begin
                rep_reg  <= '0;
                pat_reg  <= {pat_reg[5:0], 1'b0};
                left_reg <= left_reg - 3'd1;
                if (left_reg == 3'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else
            begin
                rep_reg <= rep_reg + 3'd1;
            end
        end
    end

endmodule

// File: hdl/ebe_packer.sv
module ebe_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [2:0]          start_offset,
    input  logic                bit_valid,
    output logic                bit_ready,
    input  ebe_pkg::mbit_t      mbit,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          data_byte,
    output logic                last_byte,
    output logic [3:0]          check_digit
);

    logic [7:0] byte_reg;
    logic [2:0] cnt_reg;
    logic       out_valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic [3:0] chk_reg;

    logic [2:0] cnt;
    logic [7:0] byte_new;
    logic       emit;
    logic       push;

    assign bit_ready   = !out_valid_reg || out_ready;
    assign push        = bit_valid && bit_ready;
    assign out_valid   = out_valid_reg;
    assign data_byte   = data_reg;
    assign last_byte   = last_reg;
    assign check_digit = chk_reg;

    always_comb
    begin
        // The first bit of a barcode starts a fresh byte after the offset.
        cnt      = mbit.first ? start_offset : cnt_reg;
        byte_new = mbit.first ? 8'd0 : byte_reg;
        byte_new[~cnt] = mbit.value;
        emit     = mbit.is_final || (cnt == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            byte_reg      <= '0;
            data_reg      <= '0;
            last_reg      <= 1'b0;
            chk_reg       <= '0;
        end
        else
        begin
            if (push && emit && !clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear)
            begin
                cnt_reg  <= '0;
                byte_reg <= '0;
            end
            else if (push)
            begin
                if (emit)
                begin
                    data_reg      <= byte_new;
                    last_reg      <= mbit.is_final;
                    chk_reg       <= mbit.is_final ? mbit.chk : 4'd0;
                    cnt_reg       <= '0;
                    byte_reg      <= '0;
                end
                else
                begin
                    cnt_reg  <= cnt + 3'd1;
                    byte_reg <= byte_new;
                end
            end
        end
    end

endmodule

// File: dv/ean_barcode_bit_encoder_top_test.sv
module ean_barcode_bit_encoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH_LIMIT = 4;
    localparam int DRAIN_CYCLES = 100;

    // Symbol tables, digit d at [d*7 +: 7] and parity row d at [d*6 +: 6].
    localparam logic [69:0] LEFT_ODD = {7'h0B, 7'h37, 7'h3B, 7'h2F, 7'h31,
                                        7'h23, 7'h3D, 7'h13, 7'h19, 7'h0D};
    localparam logic [69:0] LEFT_EVEN = {7'h17, 7'h09, 7'h11, 7'h05, 7'h39,
                                         7'h1D, 7'h21, 7'h1B, 7'h33, 7'h27};
    localparam logic [69:0] RIGHT_SYM = {7'h74, 7'h48, 7'h44, 7'h50, 7'h4E,
                                         7'h5C, 7'h42, 7'h6C, 7'h66, 7'h72};
    localparam logic [59:0] PARITY_ROWS = {6'h1A, 6'h16, 6'h15, 6'h1C, 6'h19,
                                           6'h13, 6'h0E, 6'h0D, 6'h0B, 6'h00};
    localparam logic [6:0] SIDE_PATTERN   = 7'h05;
    localparam logic [6:0] CENTER_PATTERN = 7'h0A;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [3:0] chk;
    } barcode_byte_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;
    logic       digit_valid;
    logic       digit_ready;
    logic [3:0] digit;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] check_digit;

    // Encoder model: configuration and code state.
    logic       fmt_ean8 = 1'b0;
    logic [2:0] module_w = 3'd1;
    logic [2:0] lead_zeros = 3'd0;
    logic [3:0] position = '0;
    logic [3:0] lead_digit = '0;
    logic [7:0] check_sum = '0;
    logic [7:0] pack_byte = '0;
    logic [2:0] pack_count = '0;

    barcode_byte_t step_bytes[$];
    barcode_byte_t expected_bytes[$];
    int fail_count = 0;

    // Sender pacing and receiver stall pattern.
    int burst_max = 1;
    int gap_max = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int run_left = 0;
    logic run_ready = 1'b1;

    ean_barcode_bit_encoder_top #(
        .MAX_MODULE_WIDTH(WIDTH_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .digit_valid(digit_valid),
        .digit_ready(digit_ready),
        .digit(digit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .check_digit(check_digit)
    );

    always #10 clk = ~clk;

    task automatic clear_code();
        position = '0;
        lead_digit = '0;
        check_sum = '0;
        pack_byte = '0;
        pack_count = '0;
    endtask

    task automatic emit_bit(input logic b);
        barcode_byte_t nb;
        if (b)
            pack_byte[7 - pack_count] = 1'b1;
        if (pack_count == 3'd7)
        begin
            nb.data = pack_byte;
            nb.last = 1'b0;
            nb.chk = 4'd0;
            step_bytes.push_back(nb);
            pack_byte = '0;
            pack_count = '0;
        end
        else
        begin
            pack_count++;
        end
    endtask

    task automatic emit_modules(input logic [6:0] pattern, input int nbits);
        int w;
        w = (module_w == 3'd0) ? 1 : ((module_w > WIDTH_LIMIT) ? WIDTH_LIMIT : module_w);
        for (int i = nbits; i > 0; i--)
            repeat (w) emit_bit(pattern[i - 1]);
    endtask

    // Works out the bytes that one accepted digit releases.
    task automatic encode_digit(input logic [3:0] raw);
        logic [3:0] d;
        logic [3:0] pos;
        logic       done;
        int         weight;
        int         chk;
        barcode_byte_t tail;
        d = (raw > 4'd9) ? 4'd9 : raw;
        pos = position;
        step_bytes.delete();
        if (pos == 4'd0)
        begin
            pack_byte = '0;
            pack_count = lead_zeros;
            emit_modules(SIDE_PATTERN, 3);
        end
        if (fmt_ean8)
        begin
            weight = pos[0] ? 1 : 3;
            if (pos < 4'd4)
                emit_modules(LEFT_ODD[d * 7 +: 7], 7);
            else
                emit_modules(RIGHT_SYM[d * 7 +: 7], 7);
            if (pos == 4'd3)
                emit_modules(CENTER_PATTERN, 5);
            done = (pos >= 4'd6);
        end
        else
        begin
            weight = pos[0] ? 3 : 1;
            if (pos == 4'd0)
            begin
                lead_digit = d;
            end
            else if (pos <= 4'd6)
            begin
                // The leading digit picks the odd or even set for each left symbol.
                if (PARITY_ROWS[int'(lead_digit) * 6 + 6 - int'(pos)])
                    emit_modules(LEFT_EVEN[d * 7 +: 7], 7);
                else
                    emit_modules(LEFT_ODD[d * 7 +: 7], 7);
                if (pos == 4'd6)
                    emit_modules(CENTER_PATTERN, 5);
            end
            else
            begin
                emit_modules(RIGHT_SYM[d * 7 +: 7], 7);
            end
            done = (pos >= 4'd11);
        end
        check_sum = check_sum + 8'(weight * int'(d));
        if (done)
        begin
            chk = (10 - (int'(check_sum) % 10)) % 10;
            emit_modules(RIGHT_SYM[chk * 7 +: 7], 7);
            emit_modules(SIDE_PATTERN, 3);
            if (pack_count != 3'd0)
            begin
                tail.data = pack_byte;
                tail.last = 1'b0;
                tail.chk = 4'd0;
                step_bytes.push_back(tail);
            end
            tail = step_bytes.pop_back();
            tail.last = 1'b1;
            tail.chk = 4'(chk);
            step_bytes.push_back(tail);
            clear_code();
        end
        else
        begin
            position = pos + 4'd1;
        end
        foreach (step_bytes[i])
            expected_bytes.push_back(step_bytes[i]);
    endtask

    // Offers one digit and waits for its transaction; valid stays high, unless a
    // gap follows the burst, so that the next digit can follow at once.
    task automatic send_digit(input logic [3:0] d);
        int gap;
        digit_valid <= 1'b1;
        digit <= d;
        @(posedge clk);
        while (!digit_ready)
            @(posedge clk);
        encode_digit(d);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                digit_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        digit_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            ebe_pkg::REG_CODE_FORMAT:  fmt_ean8 = value[0];
            ebe_pkg::REG_MODULE_WIDTH: module_w = value;
            ebe_pkg::REG_START_OFFSET: lead_zeros = value;
            default: ;
        endcase
        clear_code();
    endtask

    task automatic configure(input logic ean8, input logic [2:0] w, input logic [2:0] offset);
        settle();
        write_reg(ebe_pkg::REG_CODE_FORMAT, {2'($urandom_range(0, 3)), ean8});
        write_reg(ebe_pkg::REG_MODULE_WIDTH, w);
        write_reg(ebe_pkg::REG_START_OFFSET, offset);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                burst_max = 1;
                gap_max = 0;
                stall_pct = 0;
            end
            1:
            begin
                burst_max = 8;
                gap_max = 4;
                stall_pct = 30;
            end
            default:
            begin
                burst_max = 3;
                gap_max = 12;
                stall_pct = 60;
            end
        endcase
        burst_left = 0;
    endtask

    // Reset settings: one EAN-13 code with digits above nine and both extremes.
    task automatic test_ean13_defaults();
        logic [3:0] digits[12] = '{4'd9, 4'd0, 4'd15, 4'd10, 4'd1, 4'd2,
                                   4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};
        set_idling(1);
        foreach (digits[i])
            send_digit(digits[i]);
    endtask

    // EAN-8 with an oversized width and an offset that ends exactly on a byte.
    task automatic test_ean8_byte_boundary();
        logic [3:0] digits[7] = '{4'd0, 4'd9, 4'd12, 4'd4, 4'd8, 4'd1, 4'd6};
        configure(1'b1, 3'd7, 3'd4);
        set_idling(2);
        foreach (digits[i])
            send_digit(digits[i]);
    endtask

    // A register write in the middle of a code drops the partial code.
    task automatic test_abandoned_code();
        send_digit(4'd3);
        send_digit(4'd11);
        send_digit(4'd7);
        settle();
        write_reg(ebe_pkg::REG_MODULE_WIDTH, 3'd0);
        cfg_we <= 1'b0;
    endtask

    // The receiver holds off for a long stretch while digits keep coming.
    task automatic test_output_backpressure();
        configure(1'b0, 3'd4, 3'd7);
        set_idling(0);
        hold_request = 400;
        repeat (24) send_digit(4'($urandom_range(0, 9)));
        settle();
    endtask

    task automatic test_random_codes();
        logic       ean8;
        logic [2:0] w;
        logic [2:0] offset;
        int         sent;
        int         code_len;
        int         cut;
        for (int phase = 0; phase < 8; phase++)
        begin
            ean8 = (phase < 4) ? logic'(phase % 2) : logic'($urandom_range(0, 1));
            w = 3'($urandom_range(0, 7));
            offset = 3'($urandom_range(0, 7));
            case (phase)
                0:
                begin
                    w = 3'd4;
                    offset = 3'd7;
                end
                1:
                begin
                    w = 3'd1;
                    offset = 3'd0;
                end
                2: w = 3'd0;
                3: w = 3'd7;
                default: ;
            endcase
            configure(ean8, w, offset);
            set_idling(phase % 3);
            sent = 0;
            while (sent < 18)
            begin
                code_len = ean8 ? 7 : 12;
                // Most codes are complete; a few are cut short by a rewrite.
                cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, code_len - 1) : code_len;
                for (int k = 0; k < cut; k++)
                begin
                    if ($urandom_range(0, 99) < 8)
                        send_digit(4'($urandom_range(10, 15)));
                    else
                        send_digit(4'($urandom_range(0, 9)));
                    sent++;
                end
                if (cut < code_len)
                    configure(ean8, w, offset);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 8);
                run_ready = ($urandom_range(0, 99) >= stall_pct);
            end
            run_left--;
            out_ready <= run_ready;
        end
    end

    always @(posedge clk)
    begin
        barcode_byte_t exp_byte;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output transaction: data_byte %0h", data_byte);
                fail_count++;
            end
            else
            begin
                exp_byte = expected_bytes.pop_front();
                if (data_byte !== exp_byte.data)
                begin
                    $error("data_byte mismatch: expected %0h, actual %0h",
                           exp_byte.data, data_byte);
                    fail_count++;
                end
                if (last_byte !== exp_byte.last)
                begin
                    $error("last_byte mismatch: expected %0b, actual %0b",
                           exp_byte.last, last_byte);
                    fail_count++;
                end
                if (check_digit !== exp_byte.chk)
                begin
                    $error("check_digit mismatch: expected %0d, actual %0d",
                           exp_byte.chk, check_digit);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ebe_pkg::REG_CODE_FORMAT;
        cfg_data = '0;
        digit_valid = 1'b0;
        digit = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ean13_defaults();
        test_ean8_byte_boundary();
        test_abandoned_code();
        test_output_backpressure();
        test_random_codes();
        settle();
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
